/* rtl/tdr_pkg.sv */
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared constants, types and helpers for the tube display refresh frame block.
// ----------------------------------------------------------------------------
package tdr_pkg;

    localparam int unsigned TUBE_COUNT      = 6;
    localparam int unsigned SLOT_W          = 3;
    localparam int unsigned DIGIT_W         = 4;
    localparam int unsigned CODE_W          = 10;
    localparam int unsigned VALUE_W         = 20;
    localparam int unsigned MASK_W          = 6;
    localparam int unsigned PERIOD_W        = 16;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned WORD_W          = 32;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned BYTES_PER_FRAME = 8;
    localparam int unsigned BYTE_IDX_W      = 3;
    localparam int unsigned REG_IDX_W       = 3;
    localparam int unsigned CFG_DATA_W      = 20;
    localparam int unsigned QUEUE_DEPTH     = 2;
    localparam int unsigned QPTR_W          = 1;
    localparam int unsigned QCNT_W          = 2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_DISPLAY_VALUE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_MASK      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_UPPER_DOTS      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOWER_DOTS      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_POWER_ENABLE    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_PERIOD_MS = 3'd5;

    localparam logic [PERIOD_W-1:0]   BLINK_PERIOD_RESET = 16'd300;
    localparam logic [WORD_W-1:0]     UPPER_DOT_BIT      = 32'h8000_0000;
    localparam logic [WORD_W-1:0]     LOWER_DOT_BIT      = 32'h4000_0000;
    localparam logic [SLOT_W-1:0]     LAST_SLOT          = SLOT_W'(TUBE_COUNT - 1);
    localparam logic [SLOT_W-1:0]     LAST_DIGIT_STEP    = SLOT_W'(TUBE_COUNT - 1);
    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE          = BYTE_IDX_W'(BYTES_PER_FRAME - 1);

    // ceil(2^23 / 10): exact quotient by ten for any 20-bit value
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 20'd838861;
    localparam int unsigned        RECIP_SHIFT = 23;

    typedef logic [TUBE_COUNT-1:0][DIGIT_W-1:0] t_digits;

    typedef struct packed {
        logic              powered;
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
    } t_frame;

    function automatic logic [CODE_W-1:0] one_hot_digit(input logic [DIGIT_W-1:0] digit);
        return CODE_W'(1) << digit;
    endfunction

endpackage

/* rtl/tdr_in_if.sv */
// ----------------------------------------------------------------------------
// tdr_in_if
// Refresh tick channel: valid/ready with the millisecond time.
// ----------------------------------------------------------------------------
interface tdr_in_if import tdr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

/* rtl/tdr_out_if.sv */
// ----------------------------------------------------------------------------
// tdr_out_if
// Driver byte channel: valid/ready with one byte beat and its flags.
// ----------------------------------------------------------------------------
interface tdr_out_if import tdr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] shift_byte;
    logic              byte_valid;
    logic              drive_enable;
    logic              last_of_frame;

    modport source (output valid, output shift_byte, output byte_valid,
                    output drive_enable, output last_of_frame, input ready);
    modport sink   (input valid, input shift_byte, input byte_valid,
                    input drive_enable, input last_of_frame, output ready);
endinterface

/* rtl/tdr_digits.sv */
// ----------------------------------------------------------------------------
// tdr_digits
// Splits the display value into six decimal digits, one digit per cycle.
// ----------------------------------------------------------------------------
module tdr_digits import tdr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_busy,
    output t_digits               o_digits
);

    logic [VALUE_W-1:0]   r_work;
    logic [SLOT_W-1:0]    r_step;
    logic                 r_busy;
    t_digits              r_digits;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   rem_full;
    logic                 start;

    assign start    = i_cfg_we && (i_cfg_idx == REG_DISPLAY_VALUE);
    assign prod     = r_work * RECIP_TEN;
    assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
    assign rem_full = r_work - ((quot << 3) + (quot << 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= '0;
            r_digits <= '0;
            r_work   <= '0;
        end else if (start) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_work <= i_cfg_data[VALUE_W-1:0];
        end else if (r_busy) begin
            r_digits[r_step] <= rem_full[DIGIT_W-1:0];
            r_work           <= quot;
            r_step           <= r_step + 1'b1;
            if (r_step == LAST_DIGIT_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_digits = r_digits;

endmodule

/* rtl/tdr_front.sv */
// ----------------------------------------------------------------------------
// tdr_front
// Accepts refresh ticks, updates blink and slot state, builds driver words.
// ----------------------------------------------------------------------------
module tdr_front import tdr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_digits_busy,
    input  t_digits               i_digits,
    tdr_in_if.sink                i_in,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output t_frame                o_push_frame
);

    logic [MASK_W-1:0]   r_blink_mask;
    logic                r_upper_dots;
    logic                r_lower_dots;
    logic                r_power;
    logic [PERIOD_W-1:0] r_period;
    logic [TIME_W-1:0]   r_last_toggle;
    logic                r_phase;
    logic [SLOT_W-1:0]   r_slot;

    logic [TIME_W-1:0]   n_last_toggle;
    logic                n_phase;
    logic [SLOT_W-1:0]   n_slot;

    logic [SLOT_W-1:0]   slot_eff;
    logic [TIME_W-1:0]   elapsed;
    logic                toggle;
    logic                phase_new;
    logic [DIGIT_W-1:0]  digit;
    logic                blink_bit;
    logic [CODE_W-1:0]   code;
    logic [WORD_W-1:0]   dots;
    logic [WORD_W-1:0]   word0;
    logic [WORD_W-1:0]   word1;
    logic                accept;

    assign o_push_valid = i_in.valid && !i_digits_busy;
    assign i_in.ready   = !i_digits_busy && i_push_ready;
    assign accept       = i_in.valid && i_in.ready;

    assign slot_eff  = (r_slot > LAST_SLOT) ? '0 : r_slot;
    assign elapsed   = i_in.now_ms - r_last_toggle;
    assign toggle    = elapsed > {{(TIME_W-PERIOD_W){1'b0}}, r_period};
    assign phase_new = r_phase ^ toggle;
    assign digit     = i_digits[slot_eff];
    // slot k blinks with mask bit (last slot - k)
    assign blink_bit = r_blink_mask[LAST_SLOT - slot_eff];
    assign code      = (phase_new && blink_bit) ? '0 : one_hot_digit(digit);
    assign dots      = (r_upper_dots ? UPPER_DOT_BIT : '0) | (r_lower_dots ? LOWER_DOT_BIT : '0);

    always_comb begin
        word0 = dots;
        word1 = dots;
        case (slot_eff)
            3'd0:    word0[29:20] = code;
            3'd1:    word0[19:10] = code;
            3'd2:    word0[9:0]   = code;
            3'd3:    word1[29:20] = code;
            3'd4:    word1[19:10] = code;
            3'd5:    word1[9:0]   = code;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_push_frame.powered = r_power;
        o_push_frame.word0   = r_power ? word0 : '0;
        o_push_frame.word1   = r_power ? word1 : '0;
    end

    always_comb begin
        n_last_toggle = r_last_toggle;
        n_phase       = r_phase;
        n_slot        = r_slot;
        if (accept && r_power) begin
            if (toggle) begin
                n_last_toggle = i_in.now_ms;
            end
            n_phase = phase_new;
            n_slot  = (slot_eff == LAST_SLOT) ? '0 : slot_eff + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_toggle <= '0;
            r_phase       <= 1'b0;
            r_slot        <= '0;
        end else begin
            r_last_toggle <= n_last_toggle;
            r_phase       <= n_phase;
            r_slot        <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_mask <= '0;
            r_upper_dots <= 1'b0;
            r_lower_dots <= 1'b0;
            r_power      <= 1'b1;
            r_period     <= BLINK_PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLINK_MASK:      r_blink_mask <= i_cfg_data[MASK_W-1:0];
                REG_UPPER_DOTS:      r_upper_dots <= i_cfg_data[0];
                REG_LOWER_DOTS:      r_lower_dots <= i_cfg_data[0];
                REG_POWER_ENABLE:    r_power      <= i_cfg_data[0];
                REG_BLINK_PERIOD_MS: r_period     <= i_cfg_data[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/tdr_queue.sv */
// ----------------------------------------------------------------------------
// tdr_queue
// Short frame queue between the front and the byte serialiser.
// ----------------------------------------------------------------------------
module tdr_queue import tdr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_frame i_push_frame,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_frame o_pop_frame
);

    t_frame            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_frame  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/tdr_back.sv */
// ----------------------------------------------------------------------------
// tdr_back
// Serialises queued frames into byte beats through an output register.
// ----------------------------------------------------------------------------
module tdr_back import tdr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_frame      i_pop_frame,
    tdr_out_if.source   o_out
);

    t_frame                r_frame;
    logic [BYTE_IDX_W-1:0] r_idx;
    logic                  r_busy;
    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_byte;
    logic                  r_byte_valid;
    logic                  r_drive_enable;
    logic                  r_last;

    logic                  advance;
    logic                  cur_last;
    logic                  take;
    logic [WORD_W-1:0]     sel_word;
    logic [BYTE_W-1:0]     cur_byte;

    assign advance     = !r_out_valid || o_out.ready;
    assign cur_last    = r_frame.powered ? (r_idx == LAST_BYTE) : 1'b1;
    assign o_pop_ready = !r_busy || (advance && cur_last);
    assign take        = i_pop_valid && o_pop_ready;
    assign sel_word    = r_idx[2] ? r_frame.word1 : r_frame.word0;

    always_comb begin
        unique case (r_idx[1:0])
            2'd0: cur_byte = sel_word[31:24];
            2'd1: cur_byte = sel_word[23:16];
            2'd2: cur_byte = sel_word[15:8];
            2'd3: cur_byte = sel_word[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= r_busy;
            end
            // refill as the last beat of the current frame leaves
            if (take) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (advance && r_busy) begin
                r_idx <= r_idx + 1'b1;
                if (cur_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_frame <= i_pop_frame;
        end
        if (advance && r_busy) begin
            r_byte         <= cur_byte;
            r_byte_valid   <= r_frame.powered;
            r_drive_enable <= r_frame.powered && cur_last;
            r_last         <= cur_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.shift_byte    = r_byte;
    assign o_out.byte_valid    = r_byte_valid;
    assign o_out.drive_enable  = r_drive_enable;
    assign o_out.last_of_frame = r_last;

endmodule

/* rtl/tube_display_refresh_frame.sv */
// ----------------------------------------------------------------------------
// tube_display_refresh_frame
// Refresh frame generator for a six-tube decimal display with separator dots.
// ----------------------------------------------------------------------------
// Each beat on i_in is one refresh tick carrying the millisecond time. With
// power on it yields eight byte beats on o_out (first driver word first, MSB
// first); drive_enable rises on the last beat, which also carries
// last_of_frame. With power off a tick yields one beat with byte_valid and
// drive_enable low and last_of_frame high, and no state moves.
// A taken tick's frame is held in the queue, then in the serialiser's frame
// register; its bytes leave through the output register. Throughput: one
// byte per cycle while the receiver is ready; a two-frame queue lets ticks
// be taken while earlier frames are still shifting out.
// Writing display_value starts a split into six digits, one digit a cycle;
// i_in.ready stays low meanwhile. Other register writes take effect at once.
// Reset restores power on, a 300 ms blink period, phase visible and the
// seconds low tube lit first; the output register and queue are emptied.
// A stalled receiver holds the current beat; once the queue fills,
// i_in.ready falls until the serialiser frees an entry.
// ----------------------------------------------------------------------------
module tube_display_refresh_frame import tdr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tdr_in_if.sink                i_in,
    tdr_out_if.source             o_out
);

    logic    digits_busy;
    t_digits digits;
    logic    push_valid;
    logic    push_ready;
    t_frame  push_frame;
    logic    pop_valid;
    logic    pop_ready;
    t_frame  pop_frame;

    tdr_digits u_digits (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_busy     (digits_busy),
        .o_digits   (digits)
    );

    tdr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_digits_busy (digits_busy),
        .i_digits      (digits),
        .i_in          (i_in),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_frame  (push_frame)
    );

    tdr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_frame (push_frame),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_frame  (pop_frame)
    );

    tdr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_frame (pop_frame),
        .o_out       (o_out)
    );

endmodule

/* bench/tube_display_refresh_frame_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tube_display_refresh_frame_tb
// Self-checking bench for the refresh frame generator. Refresh ticks are
// driven on the input channel and every byte beat is checked against a
// frame predictor kept in a small scoreboard. Settings are changed between
// bursts of ticks once the output has drained. Both sides idle at random,
// and one long receiver hold-off forces the input to back up.
// ----------------------------------------------------------------------------
module tube_display_refresh_frame_tb;
    import tdr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned LONG_HOLD_CYCLES = 80;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned TAIL_CYCLES      = 20;
    localparam int unsigned RANDOM_PHASES    = 15;
    localparam int unsigned TICKS_PER_PHASE  = 30;
    localparam int unsigned MAX_REPORTS      = 10;

    // indexes past the last register, which the block must ignore
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] shift_byte;
        logic              byte_valid;
        logic              drive_enable;
        logic              last_of_frame;
    } t_beat;

    class refresh_scoreboard;
        logic [VALUE_W-1:0]  shown_value;
        logic [MASK_W-1:0]   blink_bits;
        logic                upper_on;
        logic                lower_on;
        logic                powered;
        logic [PERIOD_W-1:0] period_ms;
        logic [TIME_W-1:0]   toggle_stamp;
        logic                phase_dark;
        logic [SLOT_W-1:0]   slot;
        t_beat               due_beats[$];
        int unsigned         errors;

        function new();
            shown_value  = '0;
            blink_bits   = '0;
            upper_on     = 1'b0;
            lower_on     = 1'b0;
            powered      = 1'b1;
            period_ms    = BLINK_PERIOD_RESET;
            toggle_stamp = '0;
            phase_dark   = 1'b0;
            slot         = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DISPLAY_VALUE:   shown_value = data[VALUE_W-1:0];
                REG_BLINK_MASK:      blink_bits  = data[MASK_W-1:0];
                REG_UPPER_DOTS:      upper_on    = data[0];
                REG_LOWER_DOTS:      lower_on    = data[0];
                REG_POWER_ENABLE:    powered     = data[0];
                REG_BLINK_PERIOD_MS: period_ms   = data[PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out the beats one accepted tick yields and queue them.
        function void note_tick(logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] elapsed;
            logic [WORD_W-1:0] dots;
            logic [WORD_W-1:0] w0;
            logic [WORD_W-1:0] w1;
            logic [WORD_W-1:0] word;
            logic [WORD_W-1:0] code[TUBE_COUNT];
            int unsigned       rest;
            int unsigned       digit;
            t_beat             b;

            if (!powered) begin
                b.shift_byte    = '0;
                b.byte_valid    = 1'b0;
                b.drive_enable  = 1'b0;
                b.last_of_frame = 1'b1;
                due_beats.push_back(b);
                return;
            end
            if (slot >= TUBE_COUNT)
                slot = '0;

            elapsed = now - toggle_stamp;
            if (elapsed > {16'd0, period_ms}) begin
                toggle_stamp = now;
                phase_dark   = ~phase_dark;
            end

            // slot i is digit i counting from seconds low; its blink bit is 5 - i
            rest = shown_value;
            for (int i = 0; i < TUBE_COUNT; i++) begin
                digit   = rest % 10;
                rest    = rest / 10;
                code[i] = '0;
                if (slot == i && !(phase_dark && blink_bits[TUBE_COUNT-1-i]))
                    code[i] = WORD_W'(1) << digit;
            end

            dots = (upper_on ? UPPER_DOT_BIT : '0) | (lower_on ? LOWER_DOT_BIT : '0);
            w0   = (code[0] << 20) | (code[1] << 10) | code[2] | dots;
            w1   = (code[3] << 20) | (code[4] << 10) | code[5] | dots;

            for (int n = 0; n < BYTES_PER_FRAME; n++) begin
                word            = (n < 4) ? w0 : w1;
                b.shift_byte    = word[WORD_W-1-8*(n%4) -: BYTE_W];
                b.byte_valid    = 1'b1;
                b.drive_enable  = (n == BYTES_PER_FRAME - 1);
                b.last_of_frame = (n == BYTES_PER_FRAME - 1);
                due_beats.push_back(b);
            end

            slot = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
        endfunction

        function void check_beat(t_beat got);
            t_beat want;

            if (due_beats.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("beat with no frame pending: byte %02h valid %0b en %0b last %0b",
                             got.shift_byte, got.byte_valid, got.drive_enable,
                             got.last_of_frame);
                return;
            end
            want = due_beats.pop_front();
            if (got.shift_byte !== want.shift_byte || got.byte_valid !== want.byte_valid ||
                got.drive_enable !== want.drive_enable ||
                got.last_of_frame !== want.last_of_frame) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("beat mismatch: expected byte %02h valid %0b en %0b last %0b,",
                             want.shift_byte, want.byte_valid, want.drive_enable,
                             want.last_of_frame);
                    $display("  got byte %02h valid %0b en %0b last %0b",
                             got.shift_byte, got.byte_valid, got.drive_enable,
                             got.last_of_frame);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [REG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tdr_in_if  in_ch ();
    tdr_out_if out_ch ();

    tube_display_refresh_frame i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    refresh_scoreboard sb = new();
    logic              quiet     = 1'b0;
    logic              long_hold = 1'b0;
    int unsigned       stuck_cycles = 0;

    always #1 i_clk = ~i_clk;

    // receiver: random short stalls, one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_beat(t_beat'{out_ch.shift_byte, out_ch.byte_valid,
                                  out_ch.drive_enable, out_ch.last_of_frame});
    end

    // watchdog: too long with no beat on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("no beat for %0d cycles", stuck_cycles);
            $display("tube_display_refresh_frame test failed");
            $finish;
        end
    end

    task automatic send_tick(input logic [TIME_W-1:0] now);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.now_ms <= now;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        sb.note_tick(now);
    endtask

    // drop valid and let every owed beat come out before touching registers
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.due_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [VALUE_W-1:0] value, input logic [MASK_W-1:0] mask,
                                  input logic upper, input logic lower, input logic power,
                                  input logic [PERIOD_W-1:0] period, input logic spare);
        drain();
        write_reg(REG_DISPLAY_VALUE, CFG_DATA_W'(value));
        write_reg(REG_BLINK_MASK, CFG_DATA_W'(mask));
        write_reg(REG_UPPER_DOTS, CFG_DATA_W'(upper));
        write_reg(REG_LOWER_DOTS, CFG_DATA_W'(lower));
        write_reg(REG_POWER_ENABLE, CFG_DATA_W'(power));
        write_reg(REG_BLINK_PERIOD_MS, CFG_DATA_W'(period));
        if (spare) begin
            write_reg(REG_SPARE_A, CFG_DATA_W'($urandom()));
            write_reg(REG_SPARE_B, CFG_DATA_W'($urandom()));
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [VALUE_W-1:0]  value;
        logic [PERIOD_W-1:0] period;
        logic                power;
        logic [TIME_W-1:0]   clock_ms;
        int unsigned         leftover;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= REG_DISPLAY_VALUE;
        i_cfg_data   <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.now_ms <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // value beyond six digits, all tubes blinking, zero period, spare indexes
        apply_settings(20'hFFFFF, 6'h3F, 1'b1, 1'b0, 1'b1, 16'd0, 1'b1);
        send_tick(32'd0);
        send_tick(32'd5);
        send_tick(32'd5);
        send_tick(32'd6);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd0);

        // largest period, wrap of the elapsed time
        apply_settings(20'd999999, 6'h15, 1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b0);
        send_tick(32'h0001_0000);
        send_tick(32'h0001_0001);
        send_tick(32'h8000_0000);
        send_tick(32'h7FFF_FFFF);
        send_tick(32'h8000_FFFF);
        send_tick(32'h8001_0000);

        // power off: one dark beat per tick, state held
        apply_settings(20'd0, 6'h2A, 1'b1, 1'b1, 1'b0, 16'd1, 1'b0);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd0);
        send_tick(32'h5555_5555);

        apply_settings(20'd123456, 6'h00, 1'b0, 1'b0, 1'b1, 16'd1, 1'b1);
        send_tick(32'd10);
        send_tick(32'd11);
        send_tick(32'd12);
        send_tick(32'd14);
        send_tick(32'd20);
        clock_ms = 32'd20;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0:       value = '0;
                1:       value = 20'd999999;
                2:       value = 20'hFFFFF;
                default: value = VALUE_W'($urandom_range(0, 20'hFFFFF));
            endcase
            case ($urandom_range(0, 7))
                0:       period = 16'hFFFF;
                1:       period = 16'd1;
                2:       period = PERIOD_W'($urandom_range(0, 16'hFFFF));
                default: period = PERIOD_W'($urandom_range(2, 40));
            endcase
            power = (ph == 2) || ($urandom_range(0, 4) != 0);
            apply_settings(value, MASK_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), power, period,
                           $urandom_range(0, 5) == 0);
            quiet = (ph >= RANDOM_PHASES - 3);
            // hold the receiver off while ticks keep coming, so the queue backs up
            if (ph == 2)
                long_hold = 1'b1;
            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                if ($urandom_range(0, 15) == 0)
                    clock_ms = $urandom();
                else
                    clock_ms = clock_ms + $urandom_range(0, 2 * int'(period) + 2);
                send_tick(clock_ms);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        leftover = sb.due_beats.size();
        if (leftover != 0) begin
            $display("%0d expected beats never arrived", leftover);
            sb.errors += leftover;
        end
        if (sb.errors == 0)
            $display("tube_display_refresh_frame test passed");
        else
            $display("tube_display_refresh_frame test failed");
        $finish;
    end

endmodule
